### sv/mmm_pkg.sv
package mmm_pkg;

  // Default sizing of the filter bank
  localparam int CHANNELS_DEF   = 10;
  localparam int MAX_WINDOW_DEF = 20;

  // Fixed field widths of the request and result
  localparam int CH_W   = 4;
  localparam int WIN_W  = 5;
  localparam int DATA_W = 32;

endpackage

### sv/mmm_ram.sv
module mmm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 200
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write one word, read one word with registered data
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### sv/multichannel_moving_median_core.sv
// Moving median over a bank of channels. Each request names a channel, a
// window width and a signed Q16.16 sample; a filtered request writes the
// sample into the channel's ring and the block returns the upper median
// (rank width/2, ascending) of the first width ring entries. Width 0 passes
// the sample through; otherwise a channel of CHANNELS or more or a width of
// MAX_WINDOW or more gives 0 with range_error set. One request is handled
// at a time and in_ready is low while it is being worked on. A filtered
// request takes the ring entries in order as candidates until one is found
// to hold the median: every candidate entry is ranked by a single signed
// comparator that reads the ring one word per cycle through the single read
// port of the window RAM. The ring is zero after reset through a per-entry
// filled flag, with no clearing pass, so requests are taken from the first
// cycle after reset.
module multichannel_moving_median_core #(
  parameter int CHANNELS   = mmm_pkg::CHANNELS_DEF,
  parameter int MAX_WINDOW = mmm_pkg::MAX_WINDOW_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [mmm_pkg::CH_W-1:0]           channel,
  input  logic [mmm_pkg::WIN_W-1:0]          window_width,
  input  logic signed [mmm_pkg::DATA_W-1:0]  sample,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic signed [mmm_pkg::DATA_W-1:0]  median,
  output logic                               range_error
);

  import mmm_pkg::*;

  localparam int DEPTH = CHANNELS * MAX_WINDOW;
  localparam int AW    = $clog2(DEPTH);
  localparam int IW    = $clog2(MAX_WINDOW);
  localparam int CW    = $clog2(MAX_WINDOW + 1);
  localparam int CHW   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_PREP = 2'd1;
  localparam logic [1:0] S_SEL  = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  localparam logic [1:0] RD_NONE = 2'd0;
  localparam logic [1:0] RD_CAND = 2'd1;
  localparam logic [1:0] RD_ELEM = 2'd2;

  // Control state
  logic [1:0]          state;
  logic [CW-1:0]       k_cnt;
  logic [1:0]          rd_kind;
  logic [IW-1:0]       wptr [CHANNELS];
  logic [DEPTH-1:0]    filled;

  // Datapath registers
  logic [CHW-1:0]      ch_q;
  logic [CW-1:0]       w_q;
  logic [DATA_W-1:0]   s_q;
  logic [AW-1:0]       base_q;
  logic [IW-1:0]       idx_i;
  logic                rd_last;
  logic                rfilled;
  logic [DATA_W-1:0]   cand;
  logic [CW-1:0]       lt_cnt;
  logic [CW-1:0]       le_cnt;
  logic [DATA_W-1:0]   res_median;
  logic                res_err;

  // Combinational signals
  logic                in_acc;
  logic                w_zero;
  logic                w_bad;
  logic [CW-1:0]       p_inc;
  logic [IW-1:0]       p_next;
  logic [AW-1:0]       base_calc;
  logic [AW-1:0]       waddr;
  logic                ram_we;
  logic                issue_en;
  logic [AW-1:0]       raddr;
  logic [DATA_W-1:0]   rdata;
  logic [DATA_W-1:0]   elem;
  logic                cmp_lt;
  logic                cmp_le;
  logic [CW-1:0]       lt_new;
  logic [CW-1:0]       le_new;
  logic [CW-1:0]       half;
  logic                found;
  logic                round_end;

  assign in_ready = (state == S_IDLE);
  assign in_acc   = in_valid && in_ready;
  assign w_zero   = (window_width == '0);
  assign w_bad    = (32'(channel) >= CHANNELS) || (32'(window_width) >= MAX_WINDOW);

  // Advance the channel pointer, wrapping at the current width
  assign p_inc     = CW'(wptr[ch_q]) + CW'(1);
  assign p_next    = (p_inc >= w_q) ? '0 : IW'(p_inc);
  assign base_calc = AW'(ch_q * MAX_WINDOW);
  assign waddr     = base_calc + AW'(p_next);
  assign ram_we    = (state == S_PREP);

  // Read the candidate first, then every entry of the window
  assign issue_en = (state == S_SEL) && (k_cnt <= w_q);
  assign raddr    = base_q + ((k_cnt == '0) ? AW'(idx_i) : AW'(k_cnt - CW'(1)));

  // Shared signed comparator: ring entry against the candidate
  assign elem   = rfilled ? rdata : '0;
  assign cmp_lt = $signed(elem) < $signed(cand);
  assign cmp_le = cmp_lt || (elem == cand);
  assign lt_new = lt_cnt + CW'(cmp_lt);
  assign le_new = le_cnt + CW'(cmp_le);
  assign half   = w_q >> 1;
  assign found  = (lt_new <= half) && (le_new > half);

  assign round_end = (state == S_SEL) && (rd_kind == RD_ELEM) && rd_last;

  mmm_ram #(
    .WIDTH(DATA_W),
    .DEPTH(DEPTH)
  ) u_window (
    .clk  (clk),
    .we   (ram_we),
    .waddr(waddr),
    .wdata(s_q),
    .raddr(raddr),
    .rdata(rdata)
  );

  // Sequencer, pointers, filled flags and output handshake
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      k_cnt     <= '0;
      rd_kind   <= RD_NONE;
      filled    <= '0;
      out_valid <= 1'b0;
      for (int c = 0; c < CHANNELS; c++) begin
        wptr[c] <= '0;
      end
    end else begin
      // Raise the result once it is loaded, drop it when taken
      if ((state == S_DONE) && (!out_valid || out_ready)) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_acc) begin
            state <= (w_zero || w_bad) ? S_DONE : S_PREP;
          end
        end
        S_PREP: begin
          wptr[ch_q]    <= p_next;
          filled[waddr] <= 1'b1;
          k_cnt         <= '0;
          rd_kind       <= RD_NONE;
          state         <= S_SEL;
        end
        S_SEL: begin
          if (issue_en) begin
            rd_kind <= (k_cnt == '0) ? RD_CAND : RD_ELEM;
            k_cnt   <= k_cnt + CW'(1);
          end else begin
            rd_kind <= RD_NONE;
          end
          if (round_end) begin
            if (found) begin
              state <= S_DONE;
            end else begin
              k_cnt <= '0;
            end
          end
        end
        S_DONE: begin
          if (!out_valid || out_ready) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Request capture, ranking counters and result registers
  always_ff @(posedge clk) begin
    rfilled <= filled[raddr];
    rd_last <= issue_en && (k_cnt == w_q);
    case (state)
      S_IDLE: begin
        if (in_acc) begin
          ch_q <= CHW'(channel);
          w_q  <= CW'(window_width);
          s_q  <= sample;
          if (w_zero) begin
            res_median <= sample;
            res_err    <= 1'b0;
          end else begin
            res_median <= '0;
            res_err    <= w_bad;
          end
        end
      end
      S_PREP: begin
        base_q <= base_calc;
        idx_i  <= '0;
        lt_cnt <= '0;
        le_cnt <= '0;
      end
      S_SEL: begin
        if (rd_kind == RD_CAND) begin
          cand <= elem;
        end
        if (rd_kind == RD_ELEM) begin
          if (rd_last) begin
            lt_cnt <= '0;
            le_cnt <= '0;
            if (found) begin
              res_median <= cand;
              res_err    <= 1'b0;
            end else begin
              idx_i <= idx_i + IW'(1);
            end
          end else begin
            lt_cnt <= lt_new;
            le_cnt <= le_new;
          end
        end
      end
      S_DONE: begin
        if (!out_valid || out_ready) begin
          median      <= res_median;
          range_error <= res_err;
        end
      end
      default: begin
      end
    endcase
  end

  // A request that reaches the ring has a legal channel and a non-zero width
  a_prep_legal: assert property (@(posedge clk) disable iff (rst)
    state == S_PREP |-> (w_q != '0) && (32'(ch_q) < CHANNELS))
    else $error("ring update with illegal channel or width");

  // The candidate being ranked always lies inside the window
  a_cand_in_window: assert property (@(posedge clk) disable iff (rst)
    round_end |-> CW'(idx_i) < w_q)
    else $error("candidate index beyond window");

  // The read counter never runs past the end of a ranking round
  a_issue_bound: assert property (@(posedge clk) disable iff (rst)
    state == S_SEL |-> k_cnt <= w_q + CW'(1))
    else $error("read counter overran window");

  // A rejected request yields an error result next
  a_reject: assert property (@(posedge clk) disable iff (rst)
    in_acc && !w_zero && w_bad |=> state == S_DONE && res_err && res_median == '0)
    else $error("rejected request not flagged");

endmodule
